FILE: rtl/atna_pkg.sv
package atna_pkg;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_NEXT   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  localparam logic [1:0] SLOT_OFF      = 2'd0;
  localparam logic [1:0] SLOT_ON       = 2'd1;
  localparam logic [1:0] SLOT_DISABLED = 2'd2;

  localparam int HOUR_MAX    = 23;
  localparam int MINUTE_MAX  = 59;
  localparam int MIN_PER_DAY = 60 * 24;

  // Offsets of the second and third slot of a group from the slot before.
  localparam logic [5:0] STEP_FIRST  = 6'd3;
  localparam logic [5:0] STEP_SECOND = 6'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SET,
    ST_SCAN,
    ST_UPDATE,
    ST_MATCH,
    ST_FIX,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic set_wr;
    logic set_first;
    logic scan_en;
    logic update;
    logic match_en;
    logic fix;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  bad;
  } dp_status_t;

endpackage

FILE: rtl/atna_if.sv
interface atna_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] group;
  logic [1:0] status;
  logic [7:0] hour_bcd;
  logic [7:0] minute_bcd;
  logic [4:0] now_hour;
  logic [5:0] now_minute;
  logic       first_call;

  modport source (
    output valid, mode, group, status, hour_bcd, minute_bcd, now_hour, now_minute,
           first_call,
    input  ready
  );
  modport sink (
    input  valid, mode, group, status, hour_bcd, minute_bcd, now_hour, now_minute,
           first_call,
    output ready
  );
endinterface

interface atna_out_if;
  logic       valid;
  logic       ready;
  logic       error;
  logic [4:0] next_hour;
  logic [5:0] next_minute;
  logic [4:0] prev_hour;
  logic [5:0] prev_minute;
  logic       next_is_on;

  modport source (
    output valid, error, next_hour, next_minute, prev_hour, prev_minute, next_is_on,
    input  ready
  );
  modport sink (
    input  valid, error, next_hour, next_minute, prev_hour, prev_minute, next_is_on,
    output ready
  );
endinterface

FILE: rtl/atna_ctrl.sv
module atna_ctrl
  import atna_pkg::*;
#(
  parameter  int NUM_GROUPS = 3,
  localparam int NUM_SLOTS  = 3 * NUM_GROUPS,
  localparam int IDX_W      = $clog2(NUM_SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dp_status_t       status,
  output dp_cmd_t          cmd,
  output logic [IDX_W-1:0] idx
);

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(2);

  ctrl_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cnt_nxt = '0;
        unique case (status.mode)
          MODE_SET:   state_nxt = status.bad ? ST_DONE : ST_SET;
          MODE_NEXT:  state_nxt = ST_SCAN;
          MODE_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = ST_DONE;
          end
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_SET: begin
        cmd.set_wr    = 1'b1;
        cmd.set_first = (cnt_r == '0);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_MATCH;
      end
      ST_MATCH: begin
        cmd.match_en = 1'b1;
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // The result register is reloaded only once the previous result has gone.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idx       = cnt_r;
  assign out_valid = out_valid_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register reloaded before its transfer");

  a_set_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SET) |-> (cnt_r <= LAST_STEP))
    else $error("group write ran past its third slot");

endmodule

FILE: rtl/atna_dp.sv
module atna_dp
  import atna_pkg::*;
#(
  parameter  int NUM_GROUPS = 3,
  localparam int NUM_SLOTS  = 3 * NUM_GROUPS,
  localparam int IDX_W      = $clog2(NUM_SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic [IDX_W-1:0] idx,
  output dp_status_t       status,
  input  logic [1:0]       in_mode,
  input  logic [1:0]       in_group,
  input  logic [1:0]       in_status,
  input  logic [7:0]       in_hour_bcd,
  input  logic [7:0]       in_minute_bcd,
  input  logic [4:0]       in_now_hour,
  input  logic [5:0]       in_now_minute,
  input  logic             in_first_call,
  output logic             out_error,
  output logic [4:0]       out_next_hour,
  output logic [5:0]       out_next_minute,
  output logic [4:0]       out_prev_hour,
  output logic [5:0]       out_prev_minute,
  output logic             out_next_is_on
);

  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    return 8'({4'b0000, b[7:4]} * 8'd10) + {4'b0000, b[3:0]};
  endfunction

  // hour * 60 + minute, built from shifts.
  function automatic logic [10:0] day_minutes(input logic [4:0] h, input logic [5:0] m);
    return 11'({h, 6'b000000}) - 11'({h, 2'b00}) + 11'(m);
  endfunction

  // Slot table
  logic [1:0] slot_st_r [NUM_SLOTS];
  logic       touch_r   [NUM_SLOTS];
  logic [4:0] slot_h_r  [NUM_SLOTS];
  logic [5:0] slot_m_r  [NUM_SLOTS];

  // Item held while it is worked on
  mode_t            mode_r;
  logic [1:0]       stat_r;
  logic             bad_r;
  logic             first_r;
  logic [10:0]      now_r;
  logic [4:0]       wh_r, wh_nxt;
  logic [5:0]       wm_r, wm_nxt;
  logic [IDX_W-1:0] wptr_r;

  // Search
  logic        found_r, any_on_r;
  logic [11:0] best_r;
  logic [4:0]  best_h_r;
  logic [5:0]  best_m_r;

  // Alarm outcome
  logic [4:0] next_h_r, prev_h_r;
  logic [5:0] next_m_r, prev_m_r;
  logic       flag_r;

  logic [7:0]       conv_h, conv_m;
  logic             in_bad;
  logic [IDX_W-1:0] base;
  logic [6:0]       msum;
  logic [1:0]       rd_st;
  logic             rd_touch;
  logic [4:0]       rd_h;
  logic [5:0]       rd_m;
  logic [10:0]      t_today;
  logic [11:0]      t_late, cand;
  logic             early, late, cand_ok;

  assign conv_h = bcd_value(in_hour_bcd);
  assign conv_m = bcd_value(in_minute_bcd);
  assign in_bad = (int'(in_group) >= NUM_GROUPS) || (in_status > SLOT_DISABLED) ||
                  (conv_h > 8'(HOUR_MAX)) || (conv_m > 8'(MINUTE_MAX));
  assign base   = IDX_W'({2'b00, in_group} * 4'd3);

  // Advance the working time by three minutes after the first slot, five after the second.
  always_comb begin
    msum   = 7'(wm_r) + 7'(cmd.set_first ? STEP_FIRST : STEP_SECOND);
    wh_nxt = wh_r;
    wm_nxt = msum[5:0];
    if (msum > 7'(MINUTE_MAX)) begin
      wm_nxt = 6'(msum - 7'd60);
      wh_nxt = (wh_r == 5'(HOUR_MAX)) ? 5'd0 : wh_r + 5'd1;
    end
  end

  assign rd_st    = slot_st_r[idx];
  assign rd_touch = touch_r[idx];
  assign rd_h     = slot_h_r[idx];
  assign rd_m     = slot_m_r[idx];

  // Each slot offers its time today if that is still ahead, else its time tomorrow.
  assign t_today = day_minutes(rd_h, rd_m);
  assign t_late  = 12'(t_today) + 12'(MIN_PER_DAY);
  assign early   = now_r < t_today;
  assign late    = 12'(now_r) < t_late;
  assign cand    = early ? 12'(t_today) : t_late;
  assign cand_ok = rd_st[0] && rd_touch && (early || late);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_st_r[i] <= SLOT_DISABLED;
        touch_r[i]   <= 1'b1;
        slot_h_r[i]  <= '0;
        slot_m_r[i]  <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_st_r[i] <= SLOT_OFF;
        touch_r[i]   <= 1'b0;
        slot_h_r[i]  <= '0;
        slot_m_r[i]  <= '0;
      end
    end else if (cmd.set_wr) begin
      slot_st_r[wptr_r] <= stat_r;
      touch_r[wptr_r]   <= (stat_r == SLOT_ON) && cmd.set_first;
      if (stat_r == SLOT_ON) begin
        slot_h_r[wptr_r] <= wh_r;
        slot_m_r[wptr_r] <= wm_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode_t'(in_mode);
      stat_r  <= in_status;
      bad_r   <= in_bad;
      first_r <= in_first_call;
      now_r   <= day_minutes(in_now_hour, in_now_minute);
      wh_r    <= conv_h[4:0];
      wm_r    <= conv_m[5:0];
      wptr_r  <= base;
    end else if (cmd.set_wr) begin
      wh_r   <= wh_nxt;
      wm_r   <= wm_nxt;
      wptr_r <= wptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      any_on_r <= 1'b0;
    end else if (cmd.load) begin
      found_r  <= 1'b0;
      any_on_r <= 1'b0;
    end else if (cmd.scan_en) begin
      any_on_r <= any_on_r || rd_st[0];
      if (cand_ok && (!found_r || cand < best_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en && cand_ok && (!found_r || cand < best_r)) begin
      best_r   <= cand;
      best_h_r <= rd_h;
      best_m_r <= rd_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      next_h_r <= '0;
      next_m_r <= '0;
      prev_h_r <= '0;
      prev_m_r <= '0;
      flag_r   <= 1'b0;
    end else if (cmd.update) begin
      if (any_on_r && found_r) begin
        prev_h_r <= first_r ? best_h_r : next_h_r;
        prev_m_r <= first_r ? best_m_r : next_m_r;
        next_h_r <= best_h_r;
        next_m_r <= best_m_r;
      end
    end else if (cmd.match_en) begin
      // Later slots override earlier ones, so the highest matching slot wins.
      if (rd_h == next_h_r && rd_m == next_m_r) begin
        flag_r <= rd_st[0];
      end
    end else if (cmd.fix) begin
      if (!flag_r) begin
        next_h_r <= '0;
        next_m_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_error       <= (mode_r == MODE_UNUSED) || ((mode_r == MODE_SET) && bad_r);
      out_next_hour   <= next_h_r;
      out_next_minute <= next_m_r;
      out_prev_hour   <= prev_h_r;
      out_prev_minute <= prev_m_r;
      out_next_is_on  <= flag_r;
    end
  end

  assign status.mode = mode_r;
  assign status.bad  = bad_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_en || cmd.match_en) |-> (rd_h <= 5'(HOUR_MAX) && rd_m <= 6'(MINUTE_MAX)))
    else $error("stored alarm time out of range");

  a_next_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_h_r <= 5'(HOUR_MAX) && next_m_r <= 6'(MINUTE_MAX)))
    else $error("next alarm out of range");

  a_fix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fix && !flag_r) |=> (next_h_r == '0 && next_m_r == '0))
    else $error("next alarm kept although its slot is not on");

endmodule

FILE: rtl/alarm_table_next_alarm.sv
// A set-group item passes dispatch and then writes the slots of its group one after another;
// clear all and rejected items go from dispatch straight to done; a next-alarm search makes
// two one-slot-per-cycle passes over the slot table, scan and match, with an update step
// between them and a fix step after. One item at a time: the next item can transfer in the
// cycle its result turns valid. An item waits in done while the previous result is held.
// Reset (synchronous, rst_n low): every slot disabled with touch allowed, times zero.
module alarm_table_next_alarm
  import atna_pkg::*;
#(
  parameter int NUM_GROUPS = 3
) (
  input logic        clk,
  input logic        rst_n,
  atna_in_if.sink    in_ch,
  atna_out_if.source out_ch
);

  localparam int IDX_W = $clog2(3 * NUM_GROUPS);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] idx;

  atna_ctrl #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .idx       (idx)
  );

  atna_dp #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .idx             (idx),
    .status          (status),
    .in_mode         (in_ch.mode),
    .in_group        (in_ch.group),
    .in_status       (in_ch.status),
    .in_hour_bcd     (in_ch.hour_bcd),
    .in_minute_bcd   (in_ch.minute_bcd),
    .in_now_hour     (in_ch.now_hour),
    .in_now_minute   (in_ch.now_minute),
    .in_first_call   (in_ch.first_call),
    .out_error       (out_ch.error),
    .out_next_hour   (out_ch.next_hour),
    .out_next_minute (out_ch.next_minute),
    .out_prev_hour   (out_ch.prev_hour),
    .out_prev_minute (out_ch.prev_minute),
    .out_next_is_on  (out_ch.next_is_on)
  );

endmodule
